/* rtl/htd_pkg.sv */
// ---------------------------------------------------------------------------
// htd_pkg: shared types and constants of the Huffman tree byte decoder
// Holds the beat types of the request and response channels, the internal
// command type passed from the front end to the back end, and the state enum.
// ---------------------------------------------------------------------------
package htd_pkg;

   localparam int NODE_COUNT  = 255;
   localparam int NODE_W      = 8;
   localparam int CHILD_W     = 9;
   localparam int SYMBOL_W    = 8;
   localparam int BYTE_W      = 8;
   localparam int BIT_IDX_W   = 3;
   localparam int LIMIT_W     = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [NODE_W-1:0]    HEAD_NODE = 8'd254;
   localparam logic [NODE_W-1:0]    NULL_NODE = 8'd255;
   localparam logic [BIT_IDX_W-1:0] LAST_BIT  = 3'd7;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   typedef struct packed {
      logic                op;
      logic [NODE_W-1:0]   node_index;
      logic [CHILD_W-1:0]  child_zero;
      logic [CHILD_W-1:0]  child_one;
      logic [BYTE_W-1:0]   code_byte;
      logic                final_byte;
   } req_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                last_of_byte;
      logic                limit_reached;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_DECODE,
      CMD_SKIP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [NODE_W-1:0]   node_index;
      logic [CHILD_W-1:0]  child_zero;
      logic [CHILD_W-1:0]  child_one;
      logic [BYTE_W-1:0]   code_byte;
      logic                final_byte;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_link_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

endpackage

/* rtl/huffman_tree_byte_decoder.sv */
// ---------------------------------------------------------------------------
// huffman_tree_byte_decoder: Huffman tree walk decoder, 255 nodes, LSB first
// A node write is stored as it is popped. A decode byte is popped with a read
// of the current node, walked one bit at a time with a dependent node table
// read for each bit, and then closed in a done state; response stalls can hold
// the walk and the close. Synchronous reset clears the queue, the walk state,
// the count and the limit; the node table keeps no reset and must be written
// before it is walked.
// ---------------------------------------------------------------------------
module huffman_tree_byte_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  htd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output htd_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [31:0]      csr_data
);

   htd_pkg::cmd_link_type cmd_link;
   logic                  cmd_pop;

   htd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_link  (cmd_link),
      .cmd_pop   (cmd_pop)
   );

   htd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_link  (cmd_link),
      .cmd_pop   (cmd_pop),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/htd_front.sv */
// ---------------------------------------------------------------------------
// htd_front: request intake and command queue
// Accepts request beats, classifies them into node writes, decode commands
// or ignored writes, and holds them in a short queue for the back end.
// ---------------------------------------------------------------------------
module htd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  htd_pkg::req_type      req_data,
   output htd_pkg::cmd_link_type cmd_link,
   input  logic                  cmd_pop
);

   htd_pkg::cmd_type                q_ff [htd_pkg::QUEUE_DEPTH];
   logic [htd_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [htd_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [htd_pkg::QCNT_W-1:0]      cnt_ff, cnt_in;
   logic                            push;
   htd_pkg::cmd_type                cmd_new;

   assign req_stall = (cnt_ff == htd_pkg::QCNT_W'(htd_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;

   always_comb begin
      cmd_new.node_index = req_data.node_index;
      cmd_new.child_zero = req_data.child_zero;
      cmd_new.child_one  = req_data.child_one;
      cmd_new.code_byte  = req_data.code_byte;
      cmd_new.final_byte = req_data.final_byte;
      if (req_data.op == htd_pkg::OP_DECODE) begin
         cmd_new.kind = htd_pkg::CMD_DECODE;
      end else if (req_data.node_index == htd_pkg::NULL_NODE) begin
         cmd_new.kind = htd_pkg::CMD_SKIP;
      end else begin
         cmd_new.kind = htd_pkg::CMD_WRITE;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == htd_pkg::QPTR_W'(htd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == htd_pkg::QPTR_W'(htd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign cmd_link.valid = (cnt_ff != '0);
   assign cmd_link.cmd   = q_ff[rd_ptr_ff];

endmodule

/* rtl/htd_back.sv */
// ---------------------------------------------------------------------------
// htd_back: node table and tree walk engine
// Executes queued commands: stores tree nodes, walks the tree for decode
// commands one bit per cycle unless stalled, and registers its symbols.
// ---------------------------------------------------------------------------
module htd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  htd_pkg::cmd_link_type cmd_link,
   output logic                  cmd_pop,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [31:0]           csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output htd_pkg::rsp_type      rsp_data
);

   localparam int ENTRY_W = 2 * htd_pkg::CHILD_W;

   logic [ENTRY_W-1:0]               node_mem_ff [htd_pkg::NODE_COUNT];
   logic [ENTRY_W-1:0]               rd_data_ff;
   logic                             rd_null_ff;

   htd_pkg::state_type               state_ff, state_in;
   logic [htd_pkg::NODE_W-1:0]       node_ff, node_in;
   logic [htd_pkg::LIMIT_W-1:0]      count_ff, count_in;
   logic [htd_pkg::LIMIT_W-1:0]      limit_ff;
   logic [htd_pkg::BYTE_W-1:0]       byte_ff, byte_in;
   logic                             final_ff, final_in;
   logic [htd_pkg::BIT_IDX_W-1:0]    bit_ff, bit_in;
   logic                             pend_v_ff, pend_v_in;
   logic [htd_pkg::SYMBOL_W-1:0]     pend_sym_ff, pend_sym_in;
   logic                             pend_lim_ff, pend_lim_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   htd_pkg::rsp_type                 rsp_ff, rsp_in;

   logic                             out_free;
   logic                             out_load;
   logic                             cur_bit;
   logic [htd_pkg::CHILD_W-1:0]      child;
   logic                             is_leaf;
   logic                             stop;
   logic                             advance;
   logic                             flush_ok;
   logic                             mem_wr;
   logic [htd_pkg::LIMIT_W-1:0]      count_inc;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cur_bit   = byte_ff[bit_ff];
   assign child     = rd_null_ff ? '0 :
                      (cur_bit ? rd_data_ff[ENTRY_W-1:htd_pkg::CHILD_W] :
                                 rd_data_ff[htd_pkg::CHILD_W-1:0]);
   assign is_leaf   = !child[htd_pkg::CHILD_W-1];
   assign stop      = (count_ff >= limit_ff);
   assign advance   = !stop && !(is_leaf && pend_v_ff && !out_free);
   assign flush_ok  = !pend_v_ff || out_free;
   assign count_inc = count_ff + 32'd1;
   assign cmd_pop   = (state_ff == htd_pkg::ST_IDLE) && cmd_link.valid;
   assign mem_wr    = cmd_pop && (cmd_link.cmd.kind == htd_pkg::CMD_WRITE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         htd_pkg::ST_IDLE: begin
            if (cmd_pop && cmd_link.cmd.kind == htd_pkg::CMD_DECODE) begin
               state_in = htd_pkg::ST_WALK;
            end
         end
         htd_pkg::ST_WALK: begin
            if (stop || (advance && bit_ff == htd_pkg::LAST_BIT)) begin
               state_in = htd_pkg::ST_DONE;
            end
         end
         htd_pkg::ST_DONE: begin
            if (flush_ok) begin
               state_in = htd_pkg::ST_IDLE;
            end
         end
         default: state_in = htd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      node_in     = node_ff;
      count_in    = count_ff;
      byte_in     = byte_ff;
      final_in    = final_ff;
      bit_in      = bit_ff;
      pend_v_in   = pend_v_ff;
      pend_sym_in = pend_sym_ff;
      pend_lim_in = pend_lim_ff;
      out_load    = 1'b0;
      rsp_in      = rsp_ff;
      case (state_ff)
         htd_pkg::ST_IDLE: begin
            if (cmd_pop) begin
               byte_in  = cmd_link.cmd.code_byte;
               final_in = cmd_link.cmd.final_byte;
               bit_in   = '0;
            end
         end
         htd_pkg::ST_WALK: begin
            if (advance) begin
               bit_in = bit_ff + 1'b1;
               if (is_leaf) begin
                  node_in     = htd_pkg::HEAD_NODE;
                  count_in    = count_inc;
                  pend_v_in   = 1'b1;
                  pend_sym_in = child[htd_pkg::SYMBOL_W-1:0];
                  pend_lim_in = (count_inc == limit_ff);
                  if (pend_v_ff) begin
                     out_load             = 1'b1;
                     rsp_in.symbol        = pend_sym_ff;
                     rsp_in.last_of_byte  = 1'b0;
                     rsp_in.limit_reached = pend_lim_ff;
                  end
               end else begin
                  node_in = child[htd_pkg::NODE_W-1:0];
               end
            end
         end
         htd_pkg::ST_DONE: begin
            if (flush_ok) begin
               if (pend_v_ff) begin
                  out_load             = 1'b1;
                  pend_v_in            = 1'b0;
                  rsp_in.symbol        = pend_sym_ff;
                  rsp_in.last_of_byte  = 1'b1;
                  rsp_in.limit_reached = pend_lim_ff;
               end
               if (final_ff) begin
                  node_in  = htd_pkg::HEAD_NODE;
                  count_in = '0;
               end
            end
         end
         default: begin
            pend_v_in = 1'b0;
         end
      endcase
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= htd_pkg::ST_IDLE;
         node_ff      <= htd_pkg::HEAD_NODE;
         count_ff     <= '0;
         limit_ff     <= '0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         node_ff      <= node_in;
         count_ff     <= count_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      final_ff    <= final_in;
      bit_ff      <= bit_in;
      pend_sym_ff <= pend_sym_in;
      pend_lim_ff <= pend_lim_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         node_mem_ff[cmd_link.cmd.node_index] <= {cmd_link.cmd.child_one,
                                                  cmd_link.cmd.child_zero};
      end
      rd_data_ff <= node_mem_ff[node_in];
      rd_null_ff <= (node_in == htd_pkg::NULL_NODE);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == htd_pkg::ST_IDLE) |-> !pend_v_ff)
      else $error("Pending symbol left over after the byte finished.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("Output register loaded while a beat was still held.");

   a_last_ends_byte: assert property (@(posedge clock) disable iff (reset)
      (out_load && rsp_in.last_of_byte) |=> (state_ff == htd_pkg::ST_IDLE))
      else $error("Last symbol of a byte sent before the walk ended.");

   a_walk_starts: assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && cmd_link.cmd.kind == htd_pkg::CMD_DECODE)
      |=> (state_ff == htd_pkg::ST_WALK && bit_ff == '0))
      else $error("Decode command did not start a walk at bit zero.");

endmodule

/* tb/htd_decode_checker.sv */
// ---------------------------------------------------------------------------
// htd_decode_checker: response checker for the Huffman tree byte decoder
// Watches the request, response and register channels at the clock edge. It
// keeps its own node table, walk position, symbol count and output limit,
// expands every accepted decode beat into the symbols it must produce, and
// compares each accepted response beat field by field with the oldest one.
// ---------------------------------------------------------------------------
module htd_decode_checker
   import htd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [31:0] csr_data,
   output int          fail_count,
   output int          pending
);

   timeunit 1ns;
   timeprecision 1ps;

   logic [CHILD_W-1:0] zero_child_mem [0:NODE_COUNT-1];
   logic [CHILD_W-1:0] one_child_mem [0:NODE_COUNT-1];
   logic [NODE_W-1:0]  walk_node;
   logic [LIMIT_W-1:0] symbols_emitted;
   logic [LIMIT_W-1:0] symbol_limit;
   logic [CHILD_W-1:0] child;
   rsp_type            expected_symbols[$];
   rsp_type            byte_symbols[0:7];
   rsp_type            wanted;
   int                 byte_count;
   int                 fails = 0;

   initial begin
      for (int i = 0; i < NODE_COUNT; i++) begin
         zero_child_mem[i] = '0;
         one_child_mem[i] = '0;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         walk_node = HEAD_NODE;
         symbols_emitted = '0;
         symbol_limit = '0;
         expected_symbols.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            symbol_limit = csr_data;
         end
         if (req_valid && !req_stall) begin
            if (req_data.op == OP_WRITE) begin
               if (req_data.node_index != NULL_NODE) begin
                  zero_child_mem[req_data.node_index] = req_data.child_zero;
                  one_child_mem[req_data.node_index] = req_data.child_one;
               end
            end else begin
               byte_count = 0;
               for (int b = 0; b < 8 && symbols_emitted < symbol_limit; b++) begin
                  if (walk_node == NULL_NODE) begin
                     child = '0;
                  end else if (req_data.code_byte[b]) begin
                     child = one_child_mem[walk_node];
                  end else begin
                     child = zero_child_mem[walk_node];
                  end
                  if (!child[CHILD_W-1]) begin
                     symbols_emitted = symbols_emitted + 1;
                     byte_symbols[byte_count].symbol = child[SYMBOL_W-1:0];
                     byte_symbols[byte_count].last_of_byte = 1'b0;
                     byte_symbols[byte_count].limit_reached = (symbols_emitted == symbol_limit);
                     byte_count++;
                     walk_node = HEAD_NODE;
                  end else begin
                     walk_node = child[NODE_W-1:0];
                  end
               end
               if (byte_count > 0) begin
                  byte_symbols[byte_count-1].last_of_byte = 1'b1;
               end
               for (int i = 0; i < byte_count; i++) begin
                  expected_symbols.push_back(byte_symbols[i]);
               end
               if (req_data.final_byte) begin
                  walk_node = HEAD_NODE;
                  symbols_emitted = '0;
               end
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_symbols.size() == 0) begin
               $error("unexpected beat: symbol %0h", rsp_data.symbol);
               fails++;
            end else begin
               wanted = expected_symbols.pop_front();
               if (rsp_data.symbol !== wanted.symbol) begin
                  $error("symbol: expected %0h, got %0h", wanted.symbol, rsp_data.symbol);
                  fails++;
               end
               if (rsp_data.last_of_byte !== wanted.last_of_byte) begin
                  $error("last_of_byte: expected %0b, got %0b",
                         wanted.last_of_byte, rsp_data.last_of_byte);
                  fails++;
               end
               if (rsp_data.limit_reached !== wanted.limit_reached) begin
                  $error("limit_reached: expected %0b, got %0b",
                         wanted.limit_reached, rsp_data.limit_reached);
                  fails++;
               end
            end
         end
      end
      pending <= expected_symbols.size();
      fail_count <= fails;
   end

endmodule

/* tb/tb_huffman_tree_byte_decoder.sv */
// ---------------------------------------------------------------------------
// tb_huffman_tree_byte_decoder: testbench of the Huffman tree byte decoder
// Builds a node table that points only at written nodes or the null node, then
// sends directed and random node writes and code bytes under several output
// limits, with bursty requests and a stalling response side. The checker
// beside the block predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_huffman_tree_byte_decoder;

   timeunit 1ns;
   timeprecision 1ps;

   import htd_pkg::*;

   localparam int QUIET_CYCLES = 40;
   localparam int LONG_HOLD    = 300;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_data;
   int          fail_count;
   int          pending;
   int          holds_asked = 0;

   bit [NODE_COUNT-1:0] node_written;
   int                  written_nodes[$];

   huffman_tree_byte_decoder uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   htd_decode_checker decode_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic [CHILD_W-1:0] pick_child(input int idx);
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) begin
         pick_child = {1'b0, 8'($urandom_range(0, 255))};
      end else if (r < 8) begin
         pick_child = {1'b1, 8'(written_nodes[$urandom_range(0, written_nodes.size() - 1)])};
      end else if (r == 8) begin
         pick_child = {1'b1, 8'(idx)};
      end else begin
         pick_child = {1'b1, NULL_NODE};
      end
   endfunction

   function automatic req_type random_item(input int final_pct);
      req_type item;
      int      idx;
      item.op = ($urandom_range(0, 3) == 0) ? OP_WRITE : OP_DECODE;
      item.node_index = $urandom_range(0, 255);
      item.child_zero = $urandom_range(0, 511);
      item.child_one = $urandom_range(0, 511);
      item.code_byte = $urandom_range(0, 255);
      item.final_byte = ($urandom_range(1, 100) <= final_pct);
      if (item.op == OP_WRITE) begin
         if ($urandom_range(0, 15) == 0) begin
            item.node_index = NULL_NODE;
         end else begin
            idx = $urandom_range(0, NODE_COUNT - 1);
            item.node_index = idx;
            item.child_zero = pick_child(idx);
            item.child_one = pick_child(idx);
            if (!node_written[idx]) begin
               node_written[idx] = 1'b1;
               written_nodes.push_back(idx);
            end
         end
      end
      return item;
   endfunction

   task automatic send_item(input req_type item);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_node(input int idx, input logic [CHILD_W-1:0] c0,
                             input logic [CHILD_W-1:0] c1);
      req_type item;
      item.op = OP_WRITE;
      item.node_index = idx;
      item.child_zero = c0;
      item.child_one = c1;
      item.code_byte = $urandom_range(0, 255);
      item.final_byte = $urandom_range(0, 1);
      if (idx < NODE_COUNT && !node_written[idx]) begin
         node_written[idx] = 1'b1;
         written_nodes.push_back(idx);
      end
      send_item(item);
   endtask

   task automatic decode(input logic [7:0] code, input logic fin);
      req_type item;
      item.op = OP_DECODE;
      item.node_index = $urandom_range(0, 255);
      item.child_zero = $urandom_range(0, 511);
      item.child_one = $urandom_range(0, 511);
      item.code_byte = code;
      item.final_byte = fin;
      send_item(item);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [31:0] value, input int count, input int final_pct);
      int sent;
      int burst;
      write_limit(value);
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst && sent < count; k++) begin
            send_item(random_item(final_pct));
            sent++;
         end
         if ($urandom_range(0, 2) != 0 && sent < count) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      drain();
   endtask

   // The response side mixes free-running stretches, sparse and dense random
   // stalls, and solid stalls, and serves long holds when the stimulus asks.
   initial begin
      int holds_served;
      int mode;
      int span;
      holds_served = 0;
      forever begin
         if (holds_asked != holds_served) begin
            holds_served++;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(1, 24);
            repeat (span) begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 3) == 0);
                  2: rsp_stall <= $urandom_range(0, 1);
                  default: rsp_stall <= 1'b1;
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      node_written = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Build a small tree while the limit is still zero, so nothing decodes.
      write_node(3, 9'h0FF, {1'b1, NULL_NODE});
      write_node(HEAD_NODE, 9'h000, {1'b1, 8'd3});
      write_node(0, {1'b1, HEAD_NODE}, 9'h055);
      write_node(NULL_NODE, 9'h1FF, 9'h1FF);
      decode(8'hFF, 1'b0);
      decode(8'h5A, 1'b1);
      drain();

      write_limit(32'hFFFF_FFFF);
      decode(8'h00, 1'b0);
      decode(8'hFF, 1'b0);
      decode(8'h02, 1'b1);
      write_node(0, 9'h1FF, 9'h000);
      decode(8'hA5, 1'b1);
      drain();

      // The count stops at the limit until a final beat clears it.
      write_limit(32'd3);
      decode(8'h00, 1'b0);
      decode(8'h00, 1'b0);
      decode(8'h00, 1'b1);
      decode(8'h00, 1'b0);
      drain();

      // The limit now sits below the count left over from the last phase.
      write_limit(32'd1);
      decode(8'h00, 1'b0);
      decode(8'h00, 1'b1);
      decode(8'h00, 1'b0);
      drain();

      holds_asked <= holds_asked + 1;
      run_phase(32'hFFFF_FFFF, 40, 10);
      run_phase($urandom_range(1, 8), 30, 25);
      run_phase(32'd0, 10, 20);
      run_phase($urandom, 30, 10);
      run_phase(32'd1, 20, 30);
      run_phase($urandom_range(4, 16), 30, 15);

      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
